### hdl/hav_pkg.sv
package hav_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int ANG_W = 35;   // angle in units of 5e-8 degree, signed
   localparam int Q_W = 32;     // Q30 sine/cosine with headroom, signed
   localparam int RADDR_W = 1;

   localparam logic signed [ANG_W-1:0] TURN_U = 35'sd7200000000;
   localparam logic signed [ANG_W-1:0] HALF_TURN_U = 35'sd3600000000;
   localparam logic signed [ANG_W-1:0] QUARTER_TURN_U = 35'sd1800000000;
   localparam logic signed [Q_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;
   localparam logic [25:0] METERS_PER_U_Q32 = 26'd47757857;
   localparam logic [RADDR_W-1:0] REG_BASE_LAT = 1'b0;
   localparam logic [RADDR_W-1:0] REG_BASE_LON = 1'b1;

   function automatic logic [31:0] atan_u(input int k);
      logic [31:0] r;
      case (k)
         0: r = 32'd900000000;
         1: r = 32'd531301024;
         2: r = 32'd280724869;
         3: r = 32'd142500327;
         4: r = 32'd71526687;
         5: r = 32'd35798212;
         6: r = 32'd17903474;
         7: r = 32'd8952283;
         8: r = 32'd4476210;
         9: r = 32'd2238114;
         10: r = 32'd1119058;
         11: r = 32'd559529;
         12: r = 32'd279765;
         13: r = 32'd139882;
         14: r = 32'd69941;
         15: r = 32'd34971;
         16: r = 32'd17485;
         17: r = 32'd8743;
         18: r = 32'd4371;
         19: r = 32'd2186;
         20: r = 32'd1093;
         21: r = 32'd546;
         22: r = 32'd273;
         23: r = 32'd137;
         24: r = 32'd68;
         25: r = 32'd34;
         26: r = 32'd17;
         27: r = 32'd9;
         28: r = 32'd4;
         29: r = 32'd2;
         default: r = 32'd1;
      endcase
      return r;
   endfunction

   // Product of two Q30 values rounded to Q30
   function automatic logic signed [Q_W-1:0] rnd_q30(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
      logic signed [2*Q_W-1:0] p;
      logic signed [2*Q_W-1:0] t;
      p = a * b;
      t = (p + (64'sd1 <<< 29)) >>> 30;
      return t[Q_W-1:0];
   endfunction

endpackage

### hdl/haversine_distance.sv
// Haversine great-circle distance to a base position, fully pipelined.
// Each position passes the sine/cosine CORDIC, the haversine term, the 31-stage
// square root and the vectoring CORDIC on its way from start to rsp_valid.
// Throughput: one position per cycle; busy is always low, the receiver cannot stall.
// Reset clears valid bits and the base registers to zero.
module haversine_distance #(
   parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [30:0] req_position_latitude,
   input  logic signed [31:0] req_position_longitude,
   output logic               rsp_valid,
   output logic [24:0]        rsp_distance_meters,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:2]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import hav_pkg::*;

   logic signed [30:0] csr_base_lat_ff;
   logic signed [31:0] csr_base_lon_ff;
   logic signed [ANG_W-1:0] d_lat_in, d_lon_in, p2_in, b2_in;
   logic v0, v1, v2, v3, vt;
   logic signed [Q_W-1:0] s_lat, s_lon, c_pos, c_base, unused0, unused1, unused2, unused3;
   logic [30:0] a;
   logic vy, vx;
   logic [30:0] ya, xa;

   assign busy = 1'b0;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_base_lat_ff <= '0;
         csr_base_lon_ff <= '0;
      end else if (psel && penable && pwrite) begin
         case (paddr[2])
            REG_BASE_LAT: csr_base_lat_ff <= pwdata[30:0];
            REG_BASE_LON: csr_base_lon_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_BASE_LAT: prdata = {{1{csr_base_lat_ff[30]}}, csr_base_lat_ff};
         REG_BASE_LON: prdata = csr_base_lon_ff;
         default: prdata = '0;
      endcase
   end

   assign d_lat_in = ANG_W'(csr_base_lat_ff) - ANG_W'(req_position_latitude);
   assign d_lon_in = ANG_W'(csr_base_lon_ff) - ANG_W'(req_position_longitude);
   assign p2_in = ANG_W'(req_position_latitude) <<< 1;
   assign b2_in = ANG_W'(csr_base_lat_ff) <<< 1;

   hav_sincos #(.STAGES(CORDIC_STAGES)) u_lat (.clock, .reset, .in_valid(start),
      .in_angle(d_lat_in), .out_valid(v0), .out_sin(s_lat), .out_cos(unused0));
   hav_sincos #(.STAGES(CORDIC_STAGES)) u_lon (.clock, .reset, .in_valid(start),
      .in_angle(d_lon_in), .out_valid(v1), .out_sin(s_lon), .out_cos(unused1));
   hav_sincos #(.STAGES(CORDIC_STAGES)) u_pos (.clock, .reset, .in_valid(start),
      .in_angle(p2_in), .out_valid(v2), .out_sin(unused2), .out_cos(c_pos));
   hav_sincos #(.STAGES(CORDIC_STAGES)) u_base (.clock, .reset, .in_valid(start),
      .in_angle(b2_in), .out_valid(v3), .out_sin(unused3), .out_cos(c_base));

   hav_term u_term (.clock, .reset, .in_valid(v0 & v1 & v2 & v3), .s_lat, .s_lon,
      .c_pos, .c_base, .out_valid(vt), .out_a(a));

   // a = 1 gives a root of 2^30, so both roots carry 31 bits.
   hav_isqrt u_sqy (.clock, .reset, .in_valid(vt), .in_n({1'b0, a, 30'd0}),
      .out_valid(vy), .out_root(ya));
   hav_isqrt u_sqx (.clock, .reset, .in_valid(vt),
      .in_n({1'b0, 31'(31'(1 << 30) - a), 30'd0}), .out_valid(vx), .out_root(xa));

   hav_atan #(.STAGES(CORDIC_STAGES)) u_atan (.clock, .reset, .in_valid(vy & vx),
      .in_x(xa), .in_y(ya), .out_valid(rsp_valid), .out_dist(rsp_distance_meters));
endmodule

### hdl/hav_sincos.sv
// Pipelined rotation CORDIC: one stage per iteration, one item per cycle.
module hav_sincos #(
   parameter int STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic signed [hav_pkg::ANG_W-1:0] in_angle,
   output logic                        out_valid,
   output logic signed [hav_pkg::Q_W-1:0]   out_sin,
   output logic signed [hav_pkg::Q_W-1:0]   out_cos
);
   import hav_pkg::*;

   logic signed [ANG_W:0] wrap_in;
   logic signed [ANG_W:0] red_in;
   logic flip_in;

   logic [STAGES:0] vld_ff;
   logic signed [Q_W-1:0] x_ff [STAGES+1];
   logic signed [Q_W-1:0] y_ff [STAGES+1];
   logic signed [ANG_W-1:0] z_ff [STAGES+1];
   logic [STAGES:0] flip_ff;

   // Inputs stay within one turn of range, so a couple of corrections wrap them.
   always_comb begin
      wrap_in = {in_angle[ANG_W-1], in_angle};
      if (wrap_in > (ANG_W+1)'(HALF_TURN_U)) begin
         wrap_in = wrap_in - (ANG_W+1)'(TURN_U);
      end
      if (wrap_in <= -(ANG_W+1)'(HALF_TURN_U)) begin
         wrap_in = wrap_in + (ANG_W+1)'(TURN_U);
      end
      flip_in = 1'b0;
      red_in = wrap_in;
      if (wrap_in > (ANG_W+1)'(QUARTER_TURN_U)) begin
         red_in = wrap_in - (ANG_W+1)'(HALF_TURN_U);
         flip_in = 1'b1;
      end else if (wrap_in < -(ANG_W+1)'(QUARTER_TURN_U)) begin
         red_in = wrap_in + (ANG_W+1)'(HALF_TURN_U);
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0] <= CORDIC_INV_GAIN;
      y_ff[0] <= '0;
      z_ff[0] <= red_in[ANG_W-1:0];
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam int K = i % 32;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         flip_ff[i+1] <= flip_ff[i];
         if (!z_ff[i][ANG_W-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> K);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> K);
            z_ff[i+1] <= z_ff[i] - ANG_W'(atan_u(K));
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> K);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> K);
            z_ff[i+1] <= z_ff[i] + ANG_W'(atan_u(K));
         end
      end
   end

   assign out_valid = vld_ff[STAGES];
   assign out_sin = flip_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
   assign out_cos = flip_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
endmodule

### hdl/hav_term.sv
// Haversine term a in Q30, over three stages.
module hav_term (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [hav_pkg::Q_W-1:0] s_lat,
   input  logic signed [hav_pkg::Q_W-1:0] s_lon,
   input  logic signed [hav_pkg::Q_W-1:0] c_pos,
   input  logic signed [hav_pkg::Q_W-1:0] c_base,
   output logic                           out_valid,
   output logic [30:0]                    out_a
);
   import hav_pkg::*;

   logic [2:0] vld_ff;
   logic signed [Q_W-1:0] lat2_ff, lon2_ff, cc_ff;
   logic signed [Q_W-1:0] lat2b_ff, prod_ff;
   logic [30:0] a_ff;
   logic signed [Q_W:0] sum_in;

   always_comb begin
      sum_in = {lat2b_ff[Q_W-1], lat2b_ff} + {prod_ff[Q_W-1], prod_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
      lat2_ff <= rnd_q30(s_lat, s_lat);
      lon2_ff <= rnd_q30(s_lon, s_lon);
      cc_ff <= rnd_q30(c_pos, c_base);
      lat2b_ff <= lat2_ff;
      prod_ff <= rnd_q30(cc_ff, lon2_ff);
      // clamp to [0, 1]
      if (sum_in[Q_W]) begin
         a_ff <= '0;
      end else if (sum_in > (Q_W+1)'(1 << 30)) begin
         a_ff <= 31'(1 << 30);
      end else begin
         a_ff <= sum_in[30:0];
      end
   end

   assign out_valid = vld_ff[2];
   assign out_a = a_ff;
endmodule

### hdl/hav_isqrt.sv
// Pipelined floor square root of a 62-bit operand, one result bit per stage.
module hav_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [61:0] in_n,
   output logic        out_valid,
   output logic [30:0] out_root
);
   localparam int STEPS = 31;

   logic [STEPS:0] vld_ff;
   logic [61:0] rem_ff [STEPS+1];
   logic [30:0] root_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0] <= in_n;
      root_ff[0] <= '0;
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam int B = STEPS - 1 - i;
      logic [63:0] trial;
      assign trial = ({33'd0, root_ff[i]} << (B + 1)) + (64'd1 << (2 * B));
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if ({2'b00, rem_ff[i]} >= trial) begin
            rem_ff[i+1] <= rem_ff[i] - trial[61:0];
            root_ff[i+1] <= root_ff[i] | (31'd1 << B);
         end else begin
            rem_ff[i+1] <= rem_ff[i];
            root_ff[i+1] <= root_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_root = root_ff[STEPS];
endmodule

### hdl/hav_atan.sv
// Pipelined vectoring CORDIC, then clamp and scale to metres.
module hav_atan #(
   parameter int STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [30:0] in_x,
   input  logic [30:0] in_y,
   output logic        out_valid,
   output logic [24:0] out_dist
);
   import hav_pkg::*;

   localparam int W = 33;

   logic [STAGES+2:0] vld_ff;
   logic signed [W-1:0] x_ff [STAGES+1];
   logic signed [W-1:0] y_ff [STAGES+1];
   logic signed [ANG_W-1:0] z_ff [STAGES+1];
   logic [30:0] th_ff;
   logic [56:0] m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0] <= W'(in_x);
      y_ff[0] <= W'(in_y);
      z_ff[0] <= '0;
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam int K = i % 32;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (!y_ff[i][W-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> K);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> K);
            z_ff[i+1] <= z_ff[i] + ANG_W'(atan_u(K));
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> K);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> K);
            z_ff[i+1] <= z_ff[i] - ANG_W'(atan_u(K));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[STAGES+2:STAGES+1] <= '0;
      end else begin
         vld_ff[STAGES+2:STAGES+1] <= vld_ff[STAGES+1:STAGES];
      end
      if (z_ff[STAGES][ANG_W-1]) begin
         th_ff <= '0;
      end else if (z_ff[STAGES] > QUARTER_TURN_U) begin
         th_ff <= QUARTER_TURN_U[30:0];
      end else begin
         th_ff <= z_ff[STAGES][30:0];
      end
      m_ff <= 57'(th_ff) * 57'(METERS_PER_U_Q32) + (57'd1 << 31);
   end

   assign out_valid = vld_ff[STAGES+2];
   assign out_dist = m_ff[56:32];
endmodule
